### rtl/mwo_pkg.sv
// Shared types, constants and the sine table function of the multi-waveform oscillator.
package mwo_pkg;

  localparam int PhaseBitsDef  = 32;
  localparam int TableBitsDef  = 10;
  localparam int SampleBitsDef = 16;

  localparam int CfgDataBits = 32;
  localparam int CfgIdxBits  = 2;

  // Angle of the whole quarter table, pi/2, in Q30.
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned Q30One    = 64'd1 << 30;

  localparam logic [31:0] PhaseStepRst   = 32'd42852281;
  localparam logic [15:0] FrameLengthRst = 16'd4096;
  localparam logic [31:0] StopSampleRst  = 32'd220500;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_WAVE_KIND    = 2'd0,
    CFG_PHASE_STEP   = 2'd1,
    CFG_FRAME_LENGTH = 2'd2,
    CFG_STOP_SAMPLE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAWTOOTH = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_e;

  typedef struct packed {
    logic [1:0]  wave_kind;
    logic [31:0] phase_step;
    logic [15:0] frame_length;
    logic [31:0] stop_sample;
  } cfg_t;

  // Per-item flags that travel along the pipeline.
  typedef struct packed {
    logic last;
    logic done;
  } flags_t;

  // Quarter-wave sine entry k, evaluated at elaboration only. The Taylor series is
  // folded into Horner form with each product truncated back to Q30.
  function automatic logic [31:0] sine_entry(int unsigned k, int table_bits, int sample_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned s;
    longint unsigned v;
    longint unsigned amp;
    x   = (longint'(k) * HalfPiQ30) >> table_bits;
    x2  = (x * x) >> 30;
    amp = 64'd1 << (sample_bits - 1);
    r   = Q30One;
    r   = Q30One - ((x2 * r) >> 30) / 156;
    r   = Q30One - ((x2 * r) >> 30) / 110;
    r   = Q30One - ((x2 * r) >> 30) / 72;
    r   = Q30One - ((x2 * r) >> 30) / 42;
    r   = Q30One - ((x2 * r) >> 30) / 20;
    r   = Q30One - ((x2 * r) >> 30) / 6;
    s   = (x * r) >> 30;
    v   = (s * amp + (Q30One >> 1)) >> 30;
    if (v > amp - 1) begin
      v = amp - 1;
    end
    return v[31:0];
  endfunction

endpackage

### rtl/multi_waveform_oscillator.sv
// Top level of the multi-waveform oscillator: configuration, wave pipeline and output stage.
//
// Usage:
//   Each item accepted on the input channel (in_valid_i high, in_stall_o low) yields
//   exactly one item on the output channel: a signed sample, a frame_last flag and
//   done_res. Setting restart_i clears phase, sample count, frame position and done
//   before the item is processed.
//   Configuration registers are written through cfg_we_i / cfg_index_i / cfg_data_i
//   while the block is idle; they apply from the next item on.
//   An accepted item passes the item register in mwo_ctrl, the registered sine table
//   read and the output register. Throughput is one item per clock while out_stall_i
//   is low: the phase accumulator updates in the acceptance cycle, and the wave
//   select sits in front of the output register.
//   When the receiver asserts out_stall_i the output item holds; pipeline bubbles
//   still fill, and in_stall_o rises only once every stage holds an item.
//   Reset empties the pipeline, clears the run state and loads the default
//   configuration: sine, 4096-sample frames.
module multi_waveform_oscillator #(
  parameter int PHASE_BITS  = mwo_pkg::PhaseBitsDef,
  parameter int TABLE_BITS  = mwo_pkg::TableBitsDef,
  parameter int SAMPLE_BITS = mwo_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mwo_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [mwo_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          frame_last_o,
  output logic                          done_res_o
);
  import mwo_pkg::*;

  localparam int Amp  = 1 << (SAMPLE_BITS - 1);
  localparam int TblN = 1 << TABLE_BITS;
  localparam int Pad  = SAMPLE_BITS + 1;
  localparam int ExtBits = PHASE_BITS + Pad;

  cfg_t cfg_q;

  logic en_out, en2, en1, accept;
  logic v1_q, v2_q, out_valid_q;

  logic [PHASE_BITS-1:0] s1_phase;
  flags_t                s1_flags;

  logic [ExtBits-1:0]      ext;
  logic [TABLE_BITS+1:0]   tk;
  logic [TABLE_BITS-1:0]   idx;
  logic [TABLE_BITS:0]     addr;
  logic [SAMPLE_BITS-1:0]  saw_u;
  logic [SAMPLE_BITS:0]    tri_u;
  logic [SAMPLE_BITS:0]    tri_v;
  logic [SAMPLE_BITS-1:0]  other;

  logic                   s2_sine_q, s2_neg_q;
  logic [SAMPLE_BITS-1:0] s2_other_q;
  flags_t                 s2_flags_q;
  logic [SAMPLE_BITS-2:0] rom_data;

  logic [SAMPLE_BITS-1:0] sine_val, sample_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  flags_t                 out_flags_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_kind    <= WAVE_SINE;
      cfg_q.phase_step   <= PhaseStepRst;
      cfg_q.frame_length <= FrameLengthRst;
      cfg_q.stop_sample  <= StopSampleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WAVE_KIND:    cfg_q.wave_kind    <= cfg_data_i[1:0];
        CFG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data_i;
        CFG_FRAME_LENGTH: cfg_q.frame_length <= cfg_data_i[15:0];
        CFG_STOP_SAMPLE:  cfg_q.stop_sample  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Each stage moves on when it is empty or the stage after it moves.
  assign en_out     = !out_valid_q || !out_stall_i;
  assign en2        = !v2_q || en_out;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en_out) begin
        out_valid_q <= v2_q;
      end
    end
  end

  mwo_ctrl #(
    .PHASE_BITS(PHASE_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .restart_i(restart_i),
    .cfg_i    (cfg_q),
    .phase_o  (s1_phase),
    .flags_o  (s1_flags)
  );

  // Padding below the phase lets narrow accumulators feed wider fields.
  always_comb begin
    ext   = {s1_phase, Pad'(0)};
    tk    = ext[ExtBits-1 -: TABLE_BITS+2];
    idx   = tk[TABLE_BITS-1:0];
    addr  = tk[TABLE_BITS] ? (TABLE_BITS+1)'(TblN) - {1'b0, idx} : {1'b0, idx};
    saw_u = ext[ExtBits-1 -: SAMPLE_BITS];
    tri_u = ext[ExtBits-1 -: SAMPLE_BITS+1];

    // Above three quarters, u - 4*Amp wraps to u itself in these widths.
    if (tri_u < (SAMPLE_BITS+1)'(Amp)) begin
      tri_v = tri_u;
    end else if (tri_u < (SAMPLE_BITS+1)'(3 * Amp)) begin
      tri_v = (SAMPLE_BITS+1)'(2 * Amp) - tri_u;
    end else begin
      tri_v = tri_u;
    end

    case (wave_e'(cfg_q.wave_kind))
      WAVE_SQUARE: begin
        other = ext[ExtBits-1] ? SAMPLE_BITS'(Amp) : SAMPLE_BITS'(Amp - 1);
      end
      WAVE_SAWTOOTH: begin
        other = {~saw_u[SAMPLE_BITS-1], saw_u[SAMPLE_BITS-2:0]};
      end
      WAVE_TRIANGLE: begin
        // The peak of the falling edge reaches +1.0 and saturates.
        other = (tri_u == (SAMPLE_BITS+1)'(Amp)) ? SAMPLE_BITS'(Amp - 1)
                                                 : tri_v[SAMPLE_BITS-1:0];
      end
      default: begin
        other = '0;
      end
    endcase
  end

  mwo_sine_rom #(
    .TABLE_BITS (TABLE_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_rom (
    .clk_i (clk_i),
    .en_i  (en2),
    .addr_i(addr),
    .data_o(rom_data)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_sine_q  <= (wave_e'(cfg_q.wave_kind) == WAVE_SINE);
      s2_neg_q   <= tk[TABLE_BITS+1];
      s2_other_q <= other;
      s2_flags_q <= s1_flags;
    end
  end

  always_comb begin
    sine_val = s2_neg_q ? -{1'b0, rom_data} : {1'b0, rom_data};
    if (s2_flags_q.done) begin
      sample_d = '0;
    end else if (s2_sine_q) begin
      sample_d = sine_val;
    end else begin
      sample_d = s2_other_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      sample_q    <= sample_d;
      out_flags_q <= s2_flags_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_o     = signed'(sample_q);
  assign frame_last_o = out_flags_q.last;
  assign done_res_o   = out_flags_q.done;

endmodule

### rtl/mwo_ctrl.sv
// Run state of the oscillator: phase accumulator, sample count, frame position, stop logic.
module mwo_ctrl #(
  parameter int PHASE_BITS = mwo_pkg::PhaseBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  restart_i,
  input  mwo_pkg::cfg_t         cfg_i,
  output logic [PHASE_BITS-1:0] phase_o,
  output mwo_pkg::flags_t       flags_o
);
  import mwo_pkg::*;

  logic [PHASE_BITS-1:0] phase_q, phase_d, phase_cur;
  logic [31:0]           count_q, count_d, count_cur;
  logic [15:0]           pos_q, pos_d, pos_cur;
  logic                  fin_q, fin_cur, fin;
  logic [15:0]           flen;
  logic [16:0]           pos_inc;
  logic                  last;

  logic [PHASE_BITS-1:0] item_phase_q;
  flags_t                item_flags_q;

  always_comb begin
    phase_cur = restart_i ? '0 : phase_q;
    count_cur = restart_i ? '0 : count_q;
    pos_cur   = restart_i ? '0 : pos_q;
    fin_cur   = restart_i ? 1'b0 : fin_q;

    // The stop limit is only checked at the start of a frame.
    fin = fin_cur || ((pos_cur == '0) && (count_cur > cfg_i.stop_sample));

    flen    = (cfg_i.frame_length == '0) ? 16'd1 : cfg_i.frame_length;
    pos_inc = {1'b0, pos_cur} + 17'd1;
    last    = (pos_inc >= {1'b0, flen});

    if (fin) begin
      phase_d = phase_cur;
      count_d = count_cur;
      pos_d   = pos_cur;
    end else begin
      phase_d = phase_cur + PHASE_BITS'(cfg_i.phase_step);
      count_d = (count_cur == '1) ? count_cur : count_cur + 32'd1;
      pos_d   = last ? '0 : pos_inc[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      count_q <= '0;
      pos_q   <= '0;
      fin_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      fin_q   <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_phase_q      <= phase_cur;
      item_flags_q.last <= last && !fin;
      item_flags_q.done <= fin;
    end
  end

  assign phase_o = item_phase_q;
  assign flags_o = item_flags_q;

endmodule

### rtl/mwo_sine_rom.sv
// Quarter-wave sine table with a registered read port.
module mwo_sine_rom #(
  parameter int TABLE_BITS  = mwo_pkg::TableBitsDef,
  parameter int SAMPLE_BITS = mwo_pkg::SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [TABLE_BITS:0]    addr_i,
  output logic [SAMPLE_BITS-2:0] data_o
);
  import mwo_pkg::*;

  localparam int Depth = (1 << TABLE_BITS) + 1;

  logic [SAMPLE_BITS-2:0] rom [Depth];
  logic [SAMPLE_BITS-2:0] data_q;

  for (genvar k = 0; k < Depth; k++) begin : g_entry
    localparam logic [31:0] Entry = sine_entry(k, TABLE_BITS, SAMPLE_BITS);
    assign rom[k] = Entry[SAMPLE_BITS-2:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

### dv/multi_waveform_oscillator_test.sv
// Self-checking testbench for the multi-waveform oscillator with its own sample predictor.
`timescale 1ns / 100ps

module multi_waveform_oscillator_test;
  import mwo_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned PrintBudget = 40;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               done;
  } osc_out_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [15:0] sample_o;
  logic        frame_last_o;
  logic        done_res_o;

  multi_waveform_oscillator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_o     (sample_o),
    .frame_last_o (frame_last_o),
    .done_res_o   (done_res_o)
  );

  // Predictor copy of the registers and the run state.
  wave_e       m_wave;
  logic [31:0] m_step;
  logic [15:0] m_flen;
  logic [31:0] m_stop;
  logic [31:0] st_phase;
  logic [31:0] st_count;
  logic [15:0] st_fpos;
  bit          st_done;
  int unsigned quarter_sine [0:1024];

  bit       restart_q [$];
  osc_out_t sample_q [$];
  osc_out_t want;
  bit       item_taken = 1'b0;
  bit       next_restart;
  idle_e    idle_mode = IDLE_NONE;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned items_in = 0;
  int unsigned results = 0;
  int unsigned done_seen = 0;
  int unsigned ends_seen = 0;
  int unsigned settings = 0;
  int unsigned cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void build_quarter_sine();
    longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned s;
    longint unsigned v;
    for (int k = 0; k <= 1024; k++) begin
      x  = (longint'(k) * 64'd1686629713) >> 10;
      x2 = (x * x) >> 30;
      r  = 64'd1 << 30;
      for (int i = 0; i < 6; i++) begin
        r = (64'd1 << 30) - ((x2 * r) >> 30) / divs[i];
      end
      s = (x * r) >> 30;
      v = (s * 64'd32768 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      quarter_sine[k] = int'(v);
    end
  endfunction

  function automatic logic signed [15:0] wave_at(logic [31:0] p);
    int         v;
    logic [11:0] k;
    logic [10:0] idx;
    int         u;
    case (m_wave)
      WAVE_SINE: begin
        k   = p[31:20];
        // Odd quadrants run the quarter table backwards, reaching its top entry.
        idx = k[10] ? (11'd1024 - {1'b0, k[9:0]}) : {1'b0, k[9:0]};
        v   = int'(quarter_sine[idx]);
        if (k[11]) begin
          v = -v;
        end
      end
      WAVE_SQUARE: begin
        v = p[31] ? -32768 : 32767;
      end
      WAVE_SAWTOOTH: begin
        v = int'({16'd0, p[31:16]}) - 32768;
      end
      default: begin
        u = int'({15'd0, p[31:15]});
        if (u < 32768) begin
          v = u;
        end else if (u < 98304) begin
          v = 65536 - u;
        end else begin
          v = u - 131072;
        end
      end
    endcase
    if (v > 32767) begin
      v = 32767;
    end
    return v[15:0];
  endfunction

  function automatic osc_out_t predict_sample(bit restart);
    osc_out_t    o;
    logic [15:0] flen;
    bit          last;
    if (restart) begin
      st_phase = '0;
      st_count = '0;
      st_fpos  = '0;
      st_done  = 1'b0;
    end
    if (st_fpos == 16'd0 && st_count > m_stop) begin
      st_done = 1'b1;
    end
    if (st_done) begin
      o.sample = '0;
      o.last   = 1'b0;
      o.done   = 1'b1;
      return o;
    end
    o.sample = wave_at(st_phase);
    st_phase = st_phase + m_step;
    if (st_count != 32'hFFFF_FFFF) begin
      st_count = st_count + 32'd1;
    end
    flen    = (m_flen == 16'd0) ? 16'd1 : m_flen;
    last    = ({1'b0, st_fpos} + 17'd1) >= {1'b0, flen};
    st_fpos = last ? 16'd0 : st_fpos + 16'd1;
    o.last  = last;
    o.done  = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(string what);
    if (errors < PrintBudget) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    errors++;
  endtask

  // Input side: a held item stays put until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || item_taken) begin
        if (restart_q.size() != 0 &&
            !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 45) ||
              (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 13))) begin
          next_restart = restart_q.pop_front();
          in_valid_i <= 1'b1;
          restart_i  <= next_restart;
        end else begin
          in_valid_i <= 1'b0;
          restart_i  <= 1'($urandom_range(0, 1));
        end
      end
    end
  end

  // Output side: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 45) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 13);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      item_taken = in_valid_i && !in_stall_o;
      if (item_taken) begin
        sample_q.push_back(predict_sample(restart_i));
        items_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (sample_q.size() == 0) begin
          report_mismatch("result arrived with no sample expected");
        end else begin
          want = sample_q.pop_front();
          results++;
          if (done_res_o) begin
            done_seen++;
          end
          if (frame_last_o) begin
            ends_seen++;
          end
          if (sample_o !== want.sample) begin
            report_mismatch($sformatf("sample %0d, expected %0d", sample_o, want.sample));
          end
          if (frame_last_o !== want.last) begin
            report_mismatch($sformatf("frame_last %b, expected %b", frame_last_o, want.last));
          end
          if (done_res_o !== want.done) begin
            report_mismatch($sformatf("done_res %b, expected %b", done_res_o, want.done));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles, sample_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_index_i <= 2'($urandom_range(0, 3));
    cfg_data_i  <= $urandom;
    case (idx)
      CFG_WAVE_KIND:    m_wave = wave_e'(data[1:0]);
      CFG_PHASE_STEP:   m_step = data;
      CFG_FRAME_LENGTH: m_flen = data[15:0];
      CFG_STOP_SAMPLE:  m_stop = data;
      default: ;
    endcase
  endtask

  task automatic write_all(wave_e wave, logic [31:0] step, logic [15:0] flen,
                           logic [31:0] stop);
    write_reg(CFG_WAVE_KIND, {30'($urandom), wave});
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_FRAME_LENGTH, {16'($urandom), flen});
    write_reg(CFG_STOP_SAMPLE, stop);
    settings++;
  endtask

  // Returns once every queued item has been taken and every sample has come back.
  task automatic drain_pipe();
    while (restart_q.size() != 0 || in_valid_i || sample_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_items(bit first_restart, int unsigned n);
    restart_q.push_back(first_restart);
    for (int unsigned i = 1; i < n; i++) begin
      restart_q.push_back($urandom_range(0, 24) == 0);
    end
  endtask

  initial begin
    logic [31:0] step;
    logic [15:0] flen;
    logic [31:0] stop;
    build_quarter_sine();
    m_wave   = WAVE_SINE;
    m_step   = PhaseStepRst;
    m_flen   = FrameLengthRst;
    m_stop   = StopSampleRst;
    st_phase = '0;
    st_count = '0;
    st_fpos  = '0;
    st_done  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults, with a restart in the middle.
    restart_q = '{0, 0, 1, 0};
    drain_pipe();

    // Stop limit zero and frame length zero: done at the second frame start, restart rearms.
    write_all(WAVE_SQUARE, 32'h8000_0000, 16'd0, 32'd0);
    restart_q = '{1, 0, 0, 1, 0};
    drain_pipe();

    write_all(WAVE_SAWTOOTH, 32'hFFFF_0000, 16'd3, 32'hFFFF_FFFF);
    restart_q = '{1, 0, 0, 0};
    drain_pipe();

    // Triangle passes its saturated peak and its negative extreme.
    write_all(WAVE_TRIANGLE, 32'h2000_0000, 16'd10, 32'hFFFF_FFFF);
    restart_q = '{1, 0, 0, 0, 0, 0, 0};
    drain_pipe();

    // Frame shortened below the current position: the next sample closes the frame.
    write_all(WAVE_SINE, 32'h2000_0000, 16'd2, 32'hFFFF_FFFF);
    restart_q = '{0, 0, 0, 0};
    drain_pipe();

    for (int seg = 0; seg < 12; seg++) begin
      idle_mode = idle_e'(seg / 3);
      case ($urandom_range(0, 7))
        0: step = 32'd0;
        1: step = 32'hFFFF_FFFF;
        2: step = 32'h8000_0000;
        default: step = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0: flen = 16'd0;
        1: flen = 16'hFFFF;
        2: flen = 16'd1;
        default: flen = 16'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 5))
        0: stop = 32'd0;
        1: stop = 32'hFFFF_FFFF;
        default: stop = $urandom_range(0, 80);
      endcase
      write_all(wave_e'(seg % 4), step, flen, stop);
      send_items(1'($urandom_range(0, 1)), 42);
      if (seg == 1) begin
        // Long receiver hold-off while items keep coming, so the input backs up.
        hold_asks++;
      end
      drain_pipe();
    end

    $display("Sent %0d items across four idle profiles and %0d register settings.",
             items_in, settings);
    $display("Checked %0d samples: %0d after the stop limit, %0d closing a frame.",
             results, done_seen, ends_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
